// File: hw/rtl/uhcr_pkg.sv
// uhcr_pkg: constants, descriptor ROM functions and control types for the
// HID control responder. No dependencies.
package uhcr_pkg;

  localparam int unsigned BeatBytesDef    = 8;
  localparam int unsigned FeatureBytesDef = 64;
  localparam int unsigned PayMax          = 273;
  localparam int unsigned OffW            = 9;

  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'h06;
  localparam logic [7:0] REQ_GET_REPORT     = 8'h01;
  localparam logic [7:0] REQ_SET_REPORT     = 8'h09;
  localparam logic [1:0] TYPE_STANDARD      = 2'd0;
  localparam logic [1:0] TYPE_CLASS         = 2'd1;
  localparam logic [7:0] DT_DEVICE          = 8'h01;
  localparam logic [7:0] DT_CONFIG          = 8'h02;
  localparam logic [7:0] DT_STRING          = 8'h03;
  localparam logic [7:0] DT_HID             = 8'h21;
  localparam logic [7:0] DT_REPORT          = 8'h22;
  localparam logic [7:0] RID_A              = 8'h05;
  localparam logic [7:0] RID_B              = 8'h09;
  localparam logic [7:0] RID_C              = 8'h20;
  localparam logic [7:0] RID_OUTPUT         = 8'h02;

  typedef enum logic [3:0] {
    SRC_NONE = 4'd0, SRC_DEV = 4'd1, SRC_CFG = 4'd2, SRC_HID = 4'd3,
    SRC_RPT = 4'd4, SRC_LANG = 4'd5, SRC_MFR = 4'd6, SRC_PROD = 4'd7,
    SRC_FA = 4'd8, SRC_FB = 4'd9, SRC_FC = 4'd10, SRC_FID = 4'd11
  } src_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture request and decode
    logic emit;   // register a beat into output stage
    logic step;   // advance offset after beat taken
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last;   // current beat is the final one
  } dp_sts_t;

  localparam logic [7:0] DEV_ROM [18] = '{
    8'h12,8'h01,8'h00,8'h02,8'h00,8'h00,8'h00,8'h40,8'h4C,8'h05,8'hE6,8'h0C,
    8'h00,8'h01,8'h01,8'h02,8'h00,8'h01};

  localparam logic [7:0] CFG_ROM [41] = '{
    8'h09,8'h02,8'h29,8'h00,8'h01,8'h01,8'h00,8'hC0,8'hFA,
    8'h09,8'h04,8'h00,8'h00,8'h02,8'h03,8'h00,8'h00,8'h00,
    8'h09,8'h21,8'h11,8'h01,8'h00,8'h01,8'h22,8'h11,8'h01,
    8'h07,8'h05,8'h84,8'h03,8'h40,8'h00,8'h06,
    8'h07,8'h05,8'h03,8'h03,8'h40,8'h00,8'h06};

  localparam logic [7:0] RPT_ROM [273] = '{
    8'h05,8'h01,8'h09,8'h05,8'hA1,8'h01,8'h85,8'h01,8'h09,8'h30,8'h09,8'h31,8'h09,8'h32,8'h09,8'h35,
    8'h09,8'h33,8'h09,8'h34,8'h15,8'h00,8'h26,8'hFF,8'h00,8'h75,8'h08,8'h95,8'h06,8'h81,8'h02,8'h06,
    8'h00,8'hFF,8'h09,8'h20,8'h95,8'h01,8'h81,8'h02,8'h05,8'h01,8'h09,8'h39,8'h15,8'h00,8'h25,8'h07,
    8'h35,8'h00,8'h46,8'h3B,8'h01,8'h65,8'h14,8'h75,8'h04,8'h95,8'h01,8'h81,8'h42,8'h65,8'h00,8'h05,
    8'h09,8'h19,8'h01,8'h29,8'h0F,8'h15,8'h00,8'h25,8'h01,8'h75,8'h01,8'h95,8'h0F,8'h81,8'h02,8'h06,
    8'h00,8'hFF,8'h09,8'h21,8'h95,8'h0D,8'h81,8'h02,8'h06,8'h00,8'hFF,8'h09,8'h22,8'h15,8'h00,8'h26,
    8'hFF,8'h00,8'h75,8'h08,8'h95,8'h34,8'h81,8'h02,8'h85,8'h02,8'h09,8'h23,8'h95,8'h2F,8'h91,8'h02,
    8'h85,8'h05,8'h09,8'h33,8'h95,8'h28,8'hB1,8'h02,8'h85,8'h08,8'h09,8'h34,8'h95,8'h2F,8'hB1,8'h02,
    8'h85,8'h09,8'h09,8'h24,8'h95,8'h13,8'hB1,8'h02,8'h85,8'h0A,8'h09,8'h25,8'h95,8'h1A,8'hB1,8'h02,
    8'h85,8'h20,8'h09,8'h26,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'h21,8'h09,8'h27,8'h95,8'h04,8'hB1,8'h02,
    8'h85,8'h22,8'h09,8'h40,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'h80,8'h09,8'h28,8'h95,8'h3F,8'hB1,8'h02,
    8'h85,8'h81,8'h09,8'h29,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'h82,8'h09,8'h2A,8'h95,8'h09,8'hB1,8'h02,
    8'h85,8'h83,8'h09,8'h2B,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'h84,8'h09,8'h2C,8'h95,8'h3F,8'hB1,8'h02,
    8'h85,8'h85,8'h09,8'h2D,8'h95,8'h02,8'hB1,8'h02,8'h85,8'hA0,8'h09,8'h2E,8'h95,8'h01,8'hB1,8'h02,
    8'h85,8'hE0,8'h09,8'h2F,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'hF0,8'h09,8'h30,8'h95,8'h3F,8'hB1,8'h02,
    8'h85,8'hF1,8'h09,8'h31,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'hF2,8'h09,8'h32,8'h95,8'h0F,8'hB1,8'h02,
    8'h85,8'hF4,8'h09,8'h35,8'h95,8'h3F,8'hB1,8'h02,8'h85,8'hF5,8'h09,8'h36,8'h95,8'h03,8'hB1,8'h02,
    8'hC0};

  localparam logic [7:0] FA_ROM [36] = '{
    8'h05,8'hFC,8'hFF,8'hF3,8'hFF,8'hFC,8'hFF,8'h99,8'h22,8'h5F,8'hDD,8'h8C,8'h22,8'h59,8'hDD,8'hBC,
    8'h22,8'h3E,8'hDD,8'h1C,8'h02,8'h1C,8'h02,8'h15,8'h20,8'h15,8'hE0,8'hB5,8'h1F,8'hDD,8'hDF,8'hFD,
    8'h1F,8'hFE,8'hDF,8'h06};

  localparam logic [7:0] FB_ROM [15] = '{
    8'h09,8'h0F,8'hB1,8'hA9,8'hC1,8'hBC,8'hD0,8'h08,8'h25,8'h00,8'hB2,8'hE5,8'hBE,8'h21,8'hE4};

  localparam logic [7:0] FC_ROM [64] = '{
    8'h20,8'h4A,8'h75,8'h6E,8'h20,8'h32,8'h34,8'h20,8'h32,8'h30,8'h32,8'h34,8'h31,8'h31,8'h3A,8'h31,
    8'h36,8'h3A,8'h32,8'h31,8'h02,8'h00,8'h04,8'h00,8'h13,8'h03,8'h00,8'h00,8'h00,8'h00,8'h0F,8'h01,
    8'h41,8'h0A,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h20,8'h05,8'h00,8'h00,
    8'h2A,8'h00,8'h01,8'h00,8'h0A,8'h00,8'h02,8'h00,8'h06,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00};

  localparam logic [7:0] LANG_ROM [4] = '{8'h04, 8'h03, 8'h09, 8'h04};

  localparam logic [7:0] MFR_CHARS [30] = '{
    8'h53,8'h6F,8'h6E,8'h79,8'h20,8'h49,8'h6E,8'h74,8'h65,8'h72,8'h61,8'h63,8'h74,8'h69,8'h76,
    8'h65,8'h20,8'h45,8'h6E,8'h74,8'h65,8'h72,8'h74,8'h61,8'h69,8'h6E,8'h6D,8'h65,8'h6E,8'h74};

  localparam logic [7:0] PROD_CHARS [19] = '{
    8'h57,8'h69,8'h72,8'h65,8'h6C,8'h65,8'h73,8'h73,8'h20,8'h43,8'h6F,8'h6E,8'h74,8'h72,8'h6F,
    8'h6C,8'h6C,8'h65,8'h72};

  // string descriptor byte: length, type 0x03, then UTF-16LE characters
  function automatic logic [7:0] str_byte(input logic [OffW-1:0] a, input logic mfr);
    logic [7:0] len;
    logic [7:0] ci;
    logic [7:0] ch;
    len = mfr ? 8'd62 : 8'd40;
    ci  = 8'((a - OffW'(2)) >> 1);
    ch  = mfr ? ((ci < 8'd30) ? MFR_CHARS[ci[4:0]] : 8'h00)
              : ((ci < 8'd19) ? PROD_CHARS[ci[4:0]] : 8'h00);
    if (a == '0)            str_byte = len;
    else if (a == OffW'(1)) str_byte = DT_STRING;
    else if (a[0])          str_byte = 8'h00;
    else                    str_byte = ch;
  endfunction

  // one payload byte at address a; bytes past the source length are zero
  function automatic logic [7:0] rom_byte(input src_t s, input logic [OffW-1:0] a,
                                          input logic [7:0] rid);
    logic [7:0] b;
    b = 8'h00;
    case (s)
      SRC_DEV:  if (a < OffW'(18)) b = DEV_ROM[a[4:0]];
      SRC_CFG:  if (a < OffW'(41)) b = CFG_ROM[a[5:0]];
      SRC_HID:  if (a < OffW'(9))  b = CFG_ROM[6'(a[5:0] + 6'd18)];
      SRC_RPT:  if (a < OffW'(273)) b = RPT_ROM[a];
      SRC_LANG: if (a < OffW'(4))  b = LANG_ROM[a[1:0]];
      SRC_MFR:  if (a < OffW'(62)) b = str_byte(a, 1'b1);
      SRC_PROD: if (a < OffW'(40)) b = str_byte(a, 1'b0);
      SRC_FA:   if (a < OffW'(36)) b = FA_ROM[a[5:0]];
      SRC_FB:   if (a < OffW'(15)) b = FB_ROM[a[3:0]];
      SRC_FC:   if (a < OffW'(64)) b = FC_ROM[a[5:0]];
      SRC_FID:  if (a == '0) b = rid;
      default:  b = 8'h00;
    endcase
    rom_byte = b;
  endfunction

endpackage

// File: hw/rtl/uhcr_ctrl.sv
// uhcr_ctrl: request sequencer. Accepts a request, then drives beats out
// until the last one is taken. Uses uhcr_pkg.
module uhcr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              out_tready,
  output logic              out_tvalid,
  input  uhcr_pkg::dp_sts_t sts,
  output uhcr_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001, ST_LOAD = 4'b0010, ST_EMIT = 4'b0100, ST_SEND = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_SEND);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: if (in_tvalid) begin
        cmd.load  = 1'b1;
        state_nxt = ST_LOAD;
      end
      ST_LOAD: state_nxt = ST_EMIT;
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: if (out_tready) begin
        if (sts.last) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_EMIT;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: hw/rtl/uhcr_dp.sv
// uhcr_dp: request decode, byte offset counter and beat assembly from the
// descriptor ROMs. Uses uhcr_pkg.
module uhcr_dp #(
  parameter int unsigned BEAT_BYTES           = uhcr_pkg::BeatBytesDef,
  parameter int unsigned FEATURE_REPORT_BYTES = uhcr_pkg::FeatureBytesDef
) (
  input  logic              clk,
  input  logic [143:0]      in_tdata,
  input  logic              fwd_en,
  input  uhcr_pkg::dp_cmd_t cmd,
  output uhcr_pkg::dp_sts_t sts,
  output logic [143:0]      out_tdata,
  output logic              out_tlast
);

  localparam int unsigned W = uhcr_pkg::OffW;

  logic [31:0]       tag_r, dev_r;
  logic              dir_r, fwd_r;
  logic [W-1:0]      n_r, off_r;
  logic [7:0]        rid_r;
  uhcr_pkg::src_t    src_r;
  logic [63:0]       beat_r;
  logic [3:0]        take_r;
  logic              last_r;

  logic [1:0]  rtype;
  logic [7:0]  code, dtype, dindex, ofirst;
  logic [15:0] wlen, olen;
  logic [16:0] dlen, nclamp;
  uhcr_pkg::src_t src_nxt;
  logic           fwd_nxt;

  assign rtype  = in_tdata[71:70];
  assign code   = in_tdata[80:73];
  assign dindex = in_tdata[88:81];
  assign dtype  = in_tdata[96:89];
  assign wlen   = in_tdata[112:97];
  assign olen   = in_tdata[128:113];
  assign ofirst = in_tdata[136:129];

  always_comb begin
    src_nxt = uhcr_pkg::SRC_NONE;
    dlen    = '0;
    fwd_nxt = 1'b0;
    if (rtype == uhcr_pkg::TYPE_STANDARD && code == uhcr_pkg::REQ_GET_DESCRIPTOR) begin
      case (dtype)
        uhcr_pkg::DT_DEVICE: begin src_nxt = uhcr_pkg::SRC_DEV; dlen = 17'd18; end
        uhcr_pkg::DT_CONFIG: begin src_nxt = uhcr_pkg::SRC_CFG; dlen = 17'd41; end
        uhcr_pkg::DT_REPORT: begin src_nxt = uhcr_pkg::SRC_RPT; dlen = 17'd273; end
        uhcr_pkg::DT_HID:    begin src_nxt = uhcr_pkg::SRC_HID; dlen = 17'd9; end
        uhcr_pkg::DT_STRING: begin
          if (dindex == 8'd0) begin
            src_nxt = uhcr_pkg::SRC_LANG; dlen = 17'd4;
          end else if (dindex == 8'd1) begin
            src_nxt = uhcr_pkg::SRC_MFR; dlen = 17'd62;
          end else if (dindex == 8'd2) begin
            src_nxt = uhcr_pkg::SRC_PROD; dlen = 17'd40;
          end
        end
        default: dlen = '0;
      endcase
    end else if (rtype == uhcr_pkg::TYPE_CLASS && code == uhcr_pkg::REQ_GET_REPORT) begin
      if (dindex == uhcr_pkg::RID_A)      src_nxt = uhcr_pkg::SRC_FA;
      else if (dindex == uhcr_pkg::RID_B) src_nxt = uhcr_pkg::SRC_FB;
      else if (dindex == uhcr_pkg::RID_C) src_nxt = uhcr_pkg::SRC_FC;
      else                                src_nxt = uhcr_pkg::SRC_FID;
      dlen = 17'(FEATURE_REPORT_BYTES);
    end else if (rtype == uhcr_pkg::TYPE_CLASS && code == uhcr_pkg::REQ_SET_REPORT) begin
      fwd_nxt = !in_tdata[64] && (olen > 16'd1) && (ofirst == uhcr_pkg::RID_OUTPUT) && fwd_en;
    end
    nclamp = (dlen < {1'b0, wlen}) ? dlen : {1'b0, wlen};
    if (!in_tdata[64]) nclamp = '0;
  end

  // beat assembly for the current offset
  logic [W-1:0] remain;
  logic [3:0]   take;
  logic [63:0]  beat;

  always_comb begin
    remain = n_r - off_r;
    take   = (remain > W'(BEAT_BYTES)) ? 4'(BEAT_BYTES) : 4'(remain);
    beat   = '0;
    for (int j = 0; j < BEAT_BYTES; j++) begin
      if (4'(j) < take) begin
        beat[8*j +: 8] = uhcr_pkg::rom_byte(src_r, W'(off_r + W'(j)), rid_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tag_r <= in_tdata[31:0];
      dev_r <= in_tdata[63:32];
      dir_r <= in_tdata[64];
      rid_r <= dindex;
      src_r <= src_nxt;
      fwd_r <= fwd_nxt;
      n_r   <= W'(nclamp);
      off_r <= '0;
    end else if (cmd.step) begin
      off_r <= off_r + W'(take_r);
    end
    if (cmd.emit) begin
      beat_r <= beat;
      take_r <= take;
      last_r <= (off_r + W'(take)) >= n_r;
    end
  end

  assign sts.last  = last_r;
  assign out_tlast = last_r;
  // tdata: reply_tag, reply_device, reply_direction, actual_length, data_beat,
  // beat_bytes, forward_output, zero pad
  assign out_tdata = {1'b0, fwd_r, take_r, beat_r, n_r, dir_r, dev_r, tag_r};

endmodule

// File: hw/rtl/usb_hid_control_responder_top.sv
// usb_hid_control_responder_top: top level of the HID control responder.
// Depends on uhcr_pkg, uhcr_ctrl and uhcr_dp.
//
// One endpoint-zero setup request is taken on the in_ stream and answered
// from fixed descriptor ROMs as a run of result beats on the out_ stream,
// each up to BEAT_BYTES payload bytes, the final beat marked with tlast; an
// empty reply is one beat with zero bytes. A request is decoded and
// captured, then each of its beats (1 to 35 at eight bytes a beat) is
// assembled from the ROM into the output register and held there for one
// handshake. The next request is accepted once the last beat is taken.
// cfg_wr_en writes the output-report forwarding enable; the user must write
// it only while the block is idle, which the block itself does not enforce.
module usb_hid_control_responder_top #(
  parameter int unsigned BEAT_BYTES           = uhcr_pkg::BeatBytesDef,
  parameter int unsigned FEATURE_REPORT_BYTES = uhcr_pkg::FeatureBytesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_wr_en,
  input  logic         cfg_wr_data,   // output_forward_enable
  input  logic         in_tvalid,
  output logic         in_tready,
  // request_tag, device_id, transfer_direction, request_type, request_code,
  // request_value, request_length, out_length, out_first_byte, zero pad
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // reply_tag, reply_device, reply_direction, actual_length, data_beat,
  // beat_bytes, forward_output, zero pad
  output logic [143:0] out_tdata,
  output logic         out_tlast      // last_beat
);

  logic              fwd_en_r;
  uhcr_pkg::dp_cmd_t cmd;
  uhcr_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      fwd_en_r <= cfg_wr_data;
    end
  end

  uhcr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .sts        (sts),
    .cmd        (cmd)
  );

  uhcr_dp #(
    .BEAT_BYTES           (BEAT_BYTES),
    .FEATURE_REPORT_BYTES (FEATURE_REPORT_BYTES)
  ) u_dp (
    .clk       (clk),
    .in_tdata  (in_tdata),
    .fwd_en    (fwd_en_r),
    .cmd       (cmd),
    .sts       (sts),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for usb_hid_control_responder_top.
// Depends on uhcr_pkg (ROM constants, codes) and the responder RTL.
module testbench;

  // one expected reply beat
  typedef struct {
    logic [31:0] tag;
    logic [31:0] dev;
    logic        dir;
    logic [8:0]  alen;
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
    logic        fwd;
  } beat_t;

  localparam int unsigned CycleLimit = 600000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_wr_en = 1'b0;
  logic         cfg_wr_data = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // request_tag, device_id, transfer_direction, request_type, request_code,
  // request_value, request_length, out_length, out_first_byte, zero pad
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // reply_tag, reply_device, reply_direction, actual_length, data_beat,
  // beat_bytes, forward_output, zero pad
  logic [143:0] out_tdata;
  logic         out_tlast;

  beat_t       reply_q[$];
  logic        fwd_enable = 1'b0;  // mirror of the forwarding register
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned ready_hold = 0;     // cycles the receiver must still stall
  bit          long_stall = 1'b0;  // asks the receiver for one long hold
  bit          quiet_rx = 1'b0;    // receiver ready unless a hold is pending when set

  usb_hid_control_responder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout with %0d beats outstanding", reply_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stalls, mostly short, some long; a forced hold wins
  always @(posedge clk) begin
    if (long_stall) begin
      long_stall = 1'b0;
      out_tready <= 1'b0;
      ready_hold <= 400;
    end else if (ready_hold != 0) begin
      out_tready <= 1'b0;
      ready_hold <= ready_hold - 1;
    end else if (quiet_rx) begin
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 3) begin
      out_tready <= 1'b0;
      ready_hold <= $urandom_range(8, 40);
    end else begin
      out_tready <= ($urandom_range(0, 99) < 70);
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (err_count < 40)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // reply checker; reads pre-edge values, so no race with the RTL
  always @(posedge clk) begin
    beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (reply_q.size() == 0) begin
        report_mismatch("unexpected beat, tag", 64'(out_tdata[31:0]), 64'h0);
      end else begin
        want = reply_q[0];
        reply_q.delete(0);
        if (out_tdata[31:0] !== want.tag)
          report_mismatch("reply_tag", 64'(out_tdata[31:0]), 64'(want.tag));
        if (out_tdata[63:32] !== want.dev)
          report_mismatch("reply_device", 64'(out_tdata[63:32]), 64'(want.dev));
        if (out_tdata[64] !== want.dir)
          report_mismatch("reply_direction", 64'(out_tdata[64]), 64'(want.dir));
        if (out_tdata[73:65] !== want.alen)
          report_mismatch("actual_length", 64'(out_tdata[73:65]), 64'(want.alen));
        if (out_tdata[137:74] !== want.data)
          report_mismatch("data_beat", out_tdata[137:74], want.data);
        if (out_tdata[141:138] !== want.nbytes)
          report_mismatch("beat_bytes", 64'(out_tdata[141:138]), 64'(want.nbytes));
        if (out_tdata[142] !== want.fwd)
          report_mismatch("forward_output", 64'(out_tdata[142]), 64'(want.fwd));
        if (out_tlast !== want.last)
          report_mismatch("last_beat", 64'(out_tlast), 64'(want.last));
      end
    end
  end

  // works out the reply beats of one request and queues them
  function automatic void predict_reply(input logic [31:0] tag, input logic [31:0] dev,
                                        input logic dir, input logic [7:0] rtype,
                                        input logic [7:0] code, input logic [15:0] value,
                                        input logic [15:0] wlen, input logic [15:0] olen,
                                        input logic [7:0] ofirst);
    logic [7:0]  pay [uhcr_pkg::PayMax];
    int unsigned dlen, n, off, take;
    logic        fwd;
    logic [1:0]  kind;
    logic [7:0]  dtype, idx;
    beat_t       b;
    foreach (pay[i]) pay[i] = 8'h00;
    dlen  = 0;
    fwd   = 1'b0;
    kind  = rtype[6:5];
    dtype = value[15:8];
    idx   = value[7:0];
    if (kind == uhcr_pkg::TYPE_STANDARD && code == uhcr_pkg::REQ_GET_DESCRIPTOR) begin
      case (dtype)
        uhcr_pkg::DT_DEVICE: begin
          for (int i = 0; i < 18; i++) pay[i] = uhcr_pkg::DEV_ROM[i];
          dlen = 18;
        end
        uhcr_pkg::DT_CONFIG: begin
          for (int i = 0; i < 41; i++) pay[i] = uhcr_pkg::CFG_ROM[i];
          dlen = 41;
        end
        uhcr_pkg::DT_REPORT: begin
          for (int i = 0; i < 273; i++) pay[i] = uhcr_pkg::RPT_ROM[i];
          dlen = 273;
        end
        uhcr_pkg::DT_HID: begin
          for (int i = 0; i < 9; i++) pay[i] = uhcr_pkg::CFG_ROM[18 + i];
          dlen = 9;
        end
        uhcr_pkg::DT_STRING: begin
          if (idx == 8'd0) begin
            for (int i = 0; i < 4; i++) pay[i] = uhcr_pkg::LANG_ROM[i];
            dlen = 4;
          end else if (idx == 8'd1) begin
            for (int i = 0; i < 30; i++) pay[2 + 2 * i] = uhcr_pkg::MFR_CHARS[i];
            dlen = 62;
          end else if (idx == 8'd2) begin
            for (int i = 0; i < 19; i++) pay[2 + 2 * i] = uhcr_pkg::PROD_CHARS[i];
            dlen = 40;
          end
          if (dlen > 4) begin
            pay[0] = 8'(dlen);
            pay[1] = uhcr_pkg::DT_STRING;
          end
        end
        default: dlen = 0;
      endcase
    end else if (kind == uhcr_pkg::TYPE_CLASS && code == uhcr_pkg::REQ_GET_REPORT) begin
      if (idx == uhcr_pkg::RID_A)
        for (int i = 0; i < 36; i++) pay[i] = uhcr_pkg::FA_ROM[i];
      else if (idx == uhcr_pkg::RID_B)
        for (int i = 0; i < 15; i++) pay[i] = uhcr_pkg::FB_ROM[i];
      else if (idx == uhcr_pkg::RID_C)
        for (int i = 0; i < 64; i++) pay[i] = uhcr_pkg::FC_ROM[i];
      else pay[0] = idx;     // unknown id: zeros headed by the id
      dlen = uhcr_pkg::FeatureBytesDef;
    end else if (kind == uhcr_pkg::TYPE_CLASS && code == uhcr_pkg::REQ_SET_REPORT) begin
      fwd = (!dir && olen > 16'd1 && ofirst == uhcr_pkg::RID_OUTPUT && fwd_enable);
    end
    n = (dlen < wlen) ? dlen : wlen;
    if (!dir) n = 0;
    off = 0;
    do begin
      take = (n - off > uhcr_pkg::BeatBytesDef) ? uhcr_pkg::BeatBytesDef : n - off;
      b.tag    = tag;
      b.dev    = dev;
      b.dir    = dir;
      b.alen   = 9'(n);
      b.data   = '0;
      for (int j = 0; j < take; j++) b.data[8 * j +: 8] = pay[off + j];
      b.nbytes = 4'(take);
      b.last   = (off + take >= n);
      b.fwd    = fwd;
      reply_q = {reply_q, b};
      off += take;
    end while (off < n);
  endfunction

  // sends one request; in_tvalid stays up if no gap follows
  task automatic send_request(input logic dir, input logic [7:0] rtype,
                              input logic [7:0] code, input logic [15:0] value,
                              input logic [15:0] wlen, input logic [15:0] olen = 16'd0,
                              input logic [7:0] ofirst = 8'h00);
    logic [31:0] tag, dev;
    int unsigned gap;
    tag = $urandom();
    dev = $urandom();
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, ofirst, olen, wlen, value, code, rtype, dir, dev, tag};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_reply(tag, dev, dir, rtype, code, value, wlen, olen, ofirst);
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // waits out every expected beat plus a few cycles of settling
  task automatic drain_replies();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_forward_enable(input logic en);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= en;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    fwd_enable  = en;
    @(posedge clk);
  endtask

  function automatic logic [7:0] type_byte(input logic [1:0] kind);
    logic [7:0] t;
    t = 8'($urandom());
    t[6:5] = kind;
    return t;
  endfunction

  task automatic test_descriptors();
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_DEVICE, 8'h00},
                 16'd64);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_CONFIG, 8'h00},
                 16'hFFFF);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_CONFIG, 8'h00},
                 16'd9);
    send_request(1'b1, 8'h81, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_REPORT, 8'h00},
                 16'd300);
    send_request(1'b1, 8'h81, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_HID, 8'h00},
                 16'd9);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_STRING, 8'h00},
                 16'd255);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_STRING, 8'h01},
                 16'd255);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_STRING, 8'h02},
                 16'd13);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_STRING, 8'hFF},
                 16'd255);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {8'hFF, 8'h00}, 16'd255);
    send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_DEVICE, 8'h00},
                 16'd0);
    // out direction never carries payload
    send_request(1'b0, 8'h00, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_REPORT, 8'h00},
                 16'hFFFF);
    // vendor and reserved types
    send_request(1'b1, 8'hC0, uhcr_pkg::REQ_GET_DESCRIPTOR, {uhcr_pkg::DT_DEVICE, 8'h00},
                 16'd64);
    send_request(1'b1, 8'hE0, uhcr_pkg::REQ_GET_REPORT, 16'h0305, 16'd64);
  endtask

  task automatic test_feature_reports();
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_GET_REPORT, {8'h03, uhcr_pkg::RID_A}, 16'd64);
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_GET_REPORT, {8'h03, uhcr_pkg::RID_B}, 16'd64);
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_GET_REPORT, {8'h03, uhcr_pkg::RID_C}, 16'hFFFF);
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_GET_REPORT, 16'hFFFF, 16'd64);  // unknown id
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_GET_REPORT, {8'h03, uhcr_pkg::RID_C}, 16'd1);
  endtask

  task automatic test_forwarding(input logic en);
    write_forward_enable(en);
    send_request(1'b0, 8'h21, uhcr_pkg::REQ_SET_REPORT, 16'h0202, 16'd0, 16'd48,
                 uhcr_pkg::RID_OUTPUT);
    send_request(1'b0, 8'h21, uhcr_pkg::REQ_SET_REPORT, 16'h0202, 16'd0, 16'd1,
                 uhcr_pkg::RID_OUTPUT);
    send_request(1'b0, 8'h21, uhcr_pkg::REQ_SET_REPORT, 16'h0202, 16'd0, 16'hFFFF, 8'h03);
    send_request(1'b1, 8'hA1, uhcr_pkg::REQ_SET_REPORT, 16'h0202, 16'd64, 16'd48,
                 uhcr_pkg::RID_OUTPUT);
    send_request(1'b0, 8'h21, uhcr_pkg::REQ_SET_REPORT, 16'h0202, 16'd0, 16'd2,
                 uhcr_pkg::RID_OUTPUT);
  endtask

  // receiver holds off long while the sender keeps offering requests
  task automatic test_back_pressure();
    drain_replies();
    long_stall = 1'b1;
    for (int i = 0; i < 4; i++)
      send_request(1'b1, 8'h81, uhcr_pkg::REQ_GET_DESCRIPTOR,
                   {uhcr_pkg::DT_REPORT, 8'h00}, 16'hFFFF);
    // full-rate stretch: receiver adds no new stalls
    drain_replies();
    quiet_rx = 1'b1;
    for (int i = 0; i < 6; i++)
      send_request(1'b1, 8'h80, uhcr_pkg::REQ_GET_DESCRIPTOR,
                   {uhcr_pkg::DT_CONFIG, 8'h00}, 16'd41);
    drain_replies();
    quiet_rx = 1'b0;
  endtask

  task automatic send_random_request();
    logic [7:0]  dtypes [6];
    logic [7:0]  rids [5];
    logic [15:0] wlen;
    int unsigned pick;
    dtypes = '{uhcr_pkg::DT_DEVICE, uhcr_pkg::DT_CONFIG, uhcr_pkg::DT_REPORT,
               uhcr_pkg::DT_HID, uhcr_pkg::DT_STRING, 8'h00};
    rids   = '{uhcr_pkg::RID_A, uhcr_pkg::RID_B, uhcr_pkg::RID_C, uhcr_pkg::RID_OUTPUT,
               8'h00};
    wlen = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 80));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      send_request(($urandom_range(0, 9) != 0), type_byte(uhcr_pkg::TYPE_STANDARD),
                   uhcr_pkg::REQ_GET_DESCRIPTOR,
                   {dtypes[$urandom_range(0, 5)], 8'($urandom_range(0, 3))}, wlen);
    end else if (pick < 70) begin
      send_request(($urandom_range(0, 9) != 0), type_byte(uhcr_pkg::TYPE_CLASS),
                   uhcr_pkg::REQ_GET_REPORT,
                   {8'($urandom()), ($urandom_range(0, 1) ? rids[$urandom_range(0, 4)]
                                                           : 8'($urandom()))}, wlen);
    end else if (pick < 88) begin
      send_request(($urandom_range(0, 4) == 0), type_byte(uhcr_pkg::TYPE_CLASS),
                   uhcr_pkg::REQ_SET_REPORT,
                   16'($urandom()), wlen,
                   ($urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 3))),
                   ($urandom_range(0, 2) != 0) ? uhcr_pkg::RID_OUTPUT : 8'($urandom()));
    end else begin
      send_request(1'($urandom_range(0, 1)), 8'($urandom()), 8'($urandom()),
                   16'($urandom()), wlen, 16'($urandom()), 8'($urandom()));
    end
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      write_forward_enable(phase[0]);
      for (int i = 0; i < 22; i++) send_random_request();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_descriptors();
    test_feature_reports();
    test_forwarding(1'b1);
    test_forwarding(1'b0);
    test_back_pressure();
    test_random();
    drain_replies();
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
